@@ hw/rtl/ajt_pkg.sv @@
// Package for the arrival jitter tracker: field widths, op codes,
// the smoothing shift and the item/result structs. No dependencies.
`default_nettype none

package ajt_pkg;

  // Field widths
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned IVAL_W   = 16;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned JITTER_W = IVAL_W + FRAC_W;

  // Smoothing divisor, must be a power of two; the divide is a shift
  localparam int unsigned ALPHA_DIV   = 16;
  localparam int unsigned ALPHA_SHIFT = $clog2(ALPHA_DIV);

  // Stall limit after reset, in ms
  localparam logic [LIMIT_W-1:0] STALL_LIMIT_RESET = LIMIT_W'(500);

  // Item op codes
  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef struct packed {
    logic              op;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [JITTER_W-1:0] jitter_q8;
    logic                interval_valid;
  } result_t;

endpackage : ajt_pkg

`default_nettype wire

@@ hw/rtl/ajt_if.sv @@
// Valid/ready channel interfaces for the arrival jitter tracker.
// Depends on ajt_pkg for field widths.
`default_nettype none

interface ajt_in_if;
  import ajt_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output op, output now_ms, input ready);
  modport sink   (input valid, input op, input now_ms, output ready);
endinterface : ajt_in_if

interface ajt_out_if;
  import ajt_pkg::*;

  logic                valid;
  logic                ready;
  logic [JITTER_W-1:0] jitter_q8;
  logic                interval_valid;

  modport source (output valid, output jitter_q8, output interval_valid, input ready);
  modport sink   (input valid, input jitter_q8, input interval_valid, output ready);
endinterface : ajt_out_if

`default_nettype wire

@@ hw/rtl/arrival_jitter_tracker_top.sv @@
// Arrival jitter tracker top level: input register, tracker core, result
// register. Depends on ajt_pkg, ajt_in_if/ajt_out_if and ajt_core.
//
// Usage:
//   in_ch  carries items (op: 0 arrival, 1 tick; now_ms: time in ms).
//   out_ch returns one result per item: jitter_q8 (unsigned Q16.8 moving
//          average of interval differences) and interval_valid.
//   cfg_we/cfg_wdata write the 16-bit stall limit (500 ms after reset);
//          write only while no item is in flight.
// Path: an accepted item is held in the input register; its result is
//   loaded into the result register when the input stage advances.
// Throughput: one item per cycle while out_ch.ready holds; the state
//   update is a single 64-bit subtract, a compare and a shift-add
//   between the two registers.
// Reset (rst, synchronous): clears both pipeline stages, the average, the
//   held interval and the last arrival time, and reloads the stall limit.
// Stall: while a result waits on out_ch.ready, one more item is taken into
//   the input register and held; in_ch.ready then drops until the result
//   register drains.
`default_nettype none

module arrival_jitter_tracker_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  ajt_in_if.sink                           in_ch,
  ajt_out_if.source                        out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [ajt_pkg::LIMIT_W-1:0] cfg_wdata
);
  import ajt_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    out_valid;
  result_t out_result;
  result_t core_result;
  logic    advance;

  // Input stage moves on when the result register is free or draining
  assign advance      = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item.op     <= in_ch.op;
      s1_item.now_ms <= in_ch.now_ms;
    end
  end

  ajt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .item      (s1_item),
    .result    (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.jitter_q8      = out_result.jitter_q8;
  assign out_ch.interval_valid = out_result.interval_valid;

  // An empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("input blocked with empty result register");

  // A held item is not dropped while the output stalls
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid)
    else $error("held item lost during stall");

  // A result without a valid interval carries a zero average
  a_zero_avg: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_result.interval_valid |-> out_result.jitter_q8 == '0)
    else $error("nonzero jitter without interval");

endmodule : arrival_jitter_tracker_top

`default_nettype wire

@@ hw/rtl/ajt_core.sv @@
// Tracker state and its registered update: last arrival, last interval,
// valid mark, jitter average and the stall limit register. Uses ajt_pkg.
`default_nettype none

module ajt_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ajt_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  wire logic                          step,
  input  wire ajt_pkg::item_t                item,
  output ajt_pkg::result_t                   result
);
  import ajt_pkg::*;

  // State
  logic [LIMIT_W-1:0]  stall_limit;
  logic [TIME_W-1:0]   last_arrival;
  logic                have_arrival;    // last_arrival != 0
  logic [IVAL_W-1:0]   last_interval;
  logic                have_interval;
  logic [JITTER_W-1:0] jitter_avg;

  logic [TIME_W-1:0]   last_arrival_next;
  logic                have_arrival_next;
  logic [IVAL_W-1:0]   last_interval_next;
  logic                have_interval_next;
  logic [JITTER_W-1:0] jitter_avg_next;

  // Datapath
  logic [TIME_W-1:0]     iv;
  logic [IVAL_W-1:0]     iv_lo;
  logic                  is_stall;
  logic [IVAL_W-1:0]     diff;
  logic [JITTER_W-1:0]   target;
  logic signed [JITTER_W:0] delta;
  logic signed [JITTER_W:0] adj;
  logic signed [JITTER_W:0] avg_sum;

  // Interval since last arrival and the stall test (upper bits nonzero means huge)
  assign iv       = item.now_ms - last_arrival;
  assign iv_lo    = iv[IVAL_W-1:0];
  assign is_stall = (iv[TIME_W-1:LIMIT_W] != '0) || (iv[LIMIT_W-1:0] >= stall_limit);

  // Moving average step: avg + floor((target - avg) / ALPHA_DIV)
  assign diff    = (iv_lo > last_interval) ? (iv_lo - last_interval)
                                           : (last_interval - iv_lo);
  assign target  = {diff, {FRAC_W{1'b0}}};
  assign delta   = $signed({1'b0, target}) - $signed({1'b0, jitter_avg});
  assign adj     = delta >>> ALPHA_SHIFT;
  assign avg_sum = $signed({1'b0, jitter_avg}) + adj;

  // Next state for the item in hand
  always_comb begin
    last_arrival_next  = last_arrival;
    have_arrival_next  = have_arrival;
    last_interval_next = last_interval;
    have_interval_next = have_interval;
    jitter_avg_next    = jitter_avg;
    if (item.op == OP_ARRIVAL) begin
      if (have_arrival) begin
        if (is_stall) begin
          last_interval_next = '0;
          have_interval_next = 1'b0;
          jitter_avg_next    = '0;
        end else if (have_interval) begin
          jitter_avg_next    = avg_sum[JITTER_W-1:0];
          last_interval_next = iv_lo;
        end else begin
          last_interval_next = iv_lo;
          have_interval_next = 1'b1;
        end
      end
      last_arrival_next = item.now_ms;
      have_arrival_next = (item.now_ms != '0);
    end else if (have_arrival && is_stall) begin
      // tick a stall limit after the last arrival
      last_interval_next = '0;
      have_interval_next = 1'b0;
      jitter_avg_next    = '0;
    end
  end

  // Result reflects the state after this item
  assign result.jitter_q8      = jitter_avg_next;
  assign result.interval_valid = have_interval_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stall_limit   <= STALL_LIMIT_RESET;
      last_arrival  <= '0;
      have_arrival  <= 1'b0;
      last_interval <= '0;
      have_interval <= 1'b0;
      jitter_avg    <= '0;
    end else begin
      if (cfg_we) begin
        stall_limit <= cfg_wdata;
      end
      if (step) begin
        last_arrival  <= last_arrival_next;
        have_arrival  <= have_arrival_next;
        last_interval <= last_interval_next;
        have_interval <= have_interval_next;
        jitter_avg    <= jitter_avg_next;
      end
    end
  end

  // Without a held interval the run state is cleared
  a_clear_run: assert property (@(posedge clk) disable iff (rst)
    !have_interval |-> (jitter_avg == '0) && (last_interval == '0))
    else $error("jitter state not cleared without interval");

  // Arrival flag tracks the stored time
  a_arrival_flag: assert property (@(posedge clk) disable iff (rst)
    have_arrival == (last_arrival != '0))
    else $error("arrival flag out of step with last arrival");

  // A configuration write lands in the stall limit
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> stall_limit == $past(cfg_wdata))
    else $error("stall limit write lost");

endmodule : ajt_core

`default_nettype wire
